>>> hw/rtl/bxpm_pkg.sv
// ----------------------------------------------------------------------------
// bxpm_pkg: shared types and constants of the binary XNOR-popcount engine
// Item layouts, opcodes, register map and the digit popcount helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bxpm_pkg;

  localparam int WORD_W     = 64;   // bits in one packed sign word
  localparam int WORD_SH    = 6;    // log2 of WORD_W
  localparam int VB_W       = 15;   // width of the vector_bits register
  localparam int DOT_W      = 16;   // width of the dot product result
  localparam int IDX_W      = 4;    // width of row and column indexes
  localparam int IDX_N      = 16;   // number of codes of an index field
  localparam int WIDX_IN_W  = 8;    // width of the word index field
  localparam int DIGIT_W    = 8;    // bits counted per cycle
  localparam int DIGITS     = WORD_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);
  localparam int PC_W       = $clog2(DIGIT_W + 1);

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 2;
  localparam logic [APB_AW-1:0] ADDR_VECTOR_BITS = 2'd0;
  localparam logic [VB_W-1:0]   VECTOR_BITS_RST  = 15'd64;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_DOT     = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [IDX_W-1:0]     row_index;
    logic [IDX_W-1:0]     col_index;
    logic [WIDX_IN_W-1:0] word_index;
    logic [WORD_W-1:0]    data_word;
  } in_item_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
  } out_item_t;

  function automatic logic [PC_W-1:0] popcount_digit(input logic [DIGIT_W-1:0] d);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      n = n + PC_W'(d[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/binary_xnor_popcount_matmul.sv
// ----------------------------------------------------------------------------
// binary_xnor_popcount_matmul: binary matrix product engine
// Stores packed sign words of A rows and B columns and returns the binary
// dot product of one row and one column per compute item.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_ready    | in_data  (opcode, indexes, data word)
//   out     | out_valid / out_ready  | out_data (dot_value, out_row, out_col)
//   cfg     | psel/penable/pwrite    | paddr, pwdata, prdata (vector_bits)
//
// A compute item steps through the 64-bit word pairs one at a time: a store
// read, a load of the masked XNOR word, and then the shift register hands
// the eight 8-bit digits of the word one by one to the popcount adder.
// The longest vector is 256 words.
// Reset clears control state and sets vector_bits to 64; the stores are not
// cleared. A result waiting on out_ready does not block store writes.
`default_nettype none

module binary_xnor_popcount_matmul #(
  parameter int A_ROWS    = 16,
  parameter int B_COLS    = 16,
  parameter int MAX_WORDS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bxpm_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bxpm_pkg::out_item_t                out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bxpm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bxpm_pkg::APB_DW-1:0]   pwdata,
  output logic [bxpm_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import bxpm_pkg::*;

  localparam int MAX_BITS = WORD_W * MAX_WORDS;
  localparam int BITS_W   = $clog2(MAX_BITS + 1);
  localparam int CMP_W    = (BITS_W > VB_W) ? BITS_W : VB_W;
  localparam int DIFF_W   = BITS_W + 2;
  localparam int WIDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ROW_W    = (A_ROWS > 1) ? $clog2(A_ROWS) : 1;
  localparam int COL_W    = (B_COLS > 1) ? $clog2(B_COLS) : 1;
  localparam int A_DEPTH  = A_ROWS * MAX_WORDS;
  localparam int B_DEPTH  = B_COLS * MAX_WORDS;
  localparam int AADDR_W  = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BADDR_W  = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SHIFT,
    S_DONE
  } state_t;

  // Configuration register.
  logic [VB_W-1:0] vector_bits_r;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_VECTOR_BITS);
  assign prdata = (paddr == ADDR_VECTOR_BITS) ? APB_DW'(vector_bits_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_bits_r <= VECTOR_BITS_RST;
    end else if (cfg_we) begin
      vector_bits_r <= pwdata[VB_W-1:0];
    end
  end

  // Index folding tables: an index beyond the store wraps.
  logic [ROW_W-1:0] row_fold [IDX_N];
  logic [COL_W-1:0] col_fold [IDX_N];

  for (genvar g = 0; g < IDX_N; g++) begin : g_fold
    assign row_fold[g] = ROW_W'(g % A_ROWS);
    assign col_fold[g] = COL_W'(g % B_COLS);
  end

  // Control and datapath registers.
  state_t                  state_r;
  logic [ROW_W-1:0]        r_idx_r;
  logic [COL_W-1:0]        c_idx_r;
  logic [IDX_W-1:0]        row_r;
  logic [IDX_W-1:0]        col_r;
  logic [WIDX_W-1:0]       w_r;
  logic [WIDX_W-1:0]       last_w_r;
  logic [5:0]              rem_r;
  logic [BITS_W-1:0]       bits_r;
  logic [BITS_W-1:0]       count_r;
  logic [WORD_W-1:0]       shift_r;
  logic [DIGIT_CNT_W-1:0]  digit_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    accept;
  logic                    word_ok;
  logic [ROW_W-1:0]        in_r;
  logic [COL_W-1:0]        in_c;
  logic [CMP_W-1:0]        vb_ext;
  logic [CMP_W-1:0]        bits_sat;
  logic [CMP_W:0]          nwords;
  logic [WORD_W-1:0]       mask;
  logic signed [DIFF_W-1:0] diff;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_r    = row_fold[in_data.row_index];
  assign in_c    = col_fold[in_data.col_index];
  assign word_ok = (int'(in_data.word_index) < MAX_WORDS);

  assign vb_ext   = CMP_W'(vector_bits_r);
  assign bits_sat = (vb_ext > CMP_W'(MAX_BITS)) ? CMP_W'(MAX_BITS) : vb_ext;
  assign nwords   = ((CMP_W + 1)'(bits_sat) + (CMP_W + 1)'(WORD_W - 1)) >> WORD_SH;

  // The last word keeps only its low rem bits when the length is not whole.
  assign mask = ((rem_r != 6'd0) && (w_r == last_w_r)) ?
                ((WORD_W'(1) << rem_r) - WORD_W'(1)) : '1;

  assign diff = DIFF_W'({count_r, 1'b0}) - DIFF_W'(bits_r);

  // Word stores.
  logic [WORD_W-1:0]  a_mem [A_DEPTH];
  logic [WORD_W-1:0]  b_mem [B_DEPTH];
  logic [WORD_W-1:0]  a_rdata_r;
  logic [WORD_W-1:0]  b_rdata_r;
  logic               a_we;
  logic               b_we;
  logic [AADDR_W-1:0] a_waddr;
  logic [BADDR_W-1:0] b_waddr;
  logic [AADDR_W-1:0] a_raddr;
  logic [BADDR_W-1:0] b_raddr;

  assign a_we    = accept && (in_data.opcode == OP_WRITE_A) && word_ok;
  assign b_we    = accept && (in_data.opcode == OP_WRITE_B) && word_ok;
  assign a_waddr = AADDR_W'(int'(in_r) * MAX_WORDS + int'(in_data.word_index));
  assign b_waddr = BADDR_W'(int'(in_c) * MAX_WORDS + int'(in_data.word_index));
  assign a_raddr = AADDR_W'(int'(r_idx_r) * MAX_WORDS + int'(w_r));
  assign b_raddr = BADDR_W'(int'(c_idx_r) * MAX_WORDS + int'(w_r));

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_data.data_word;
    end
    a_rdata_r <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= in_data.data_word;
    end
    b_rdata_r <= b_mem[b_raddr];
  end

  // Sequencer: one word pair at a time, one digit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      digit_r     <= '0;
      w_r         <= '0;
    end else begin
      // In S_DONE the result register is handled by the state arm alone.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_data.opcode == OP_DOT)) begin
            r_idx_r  <= in_r;
            c_idx_r  <= in_c;
            row_r    <= in_data.row_index;
            col_r    <= in_data.col_index;
            w_r      <= '0;
            last_w_r <= WIDX_W'(nwords - (CMP_W + 1)'(1));
            rem_r    <= bits_sat[5:0];
            bits_r   <= BITS_W'(bits_sat);
            count_r  <= '0;
            // A zero length reads no words.
            state_r  <= (nwords == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          shift_r <= ~(a_rdata_r ^ b_rdata_r) & mask;
          digit_r <= '0;
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          count_r <= count_r + BITS_W'(popcount_digit(shift_r[DIGIT_W-1:0]));
          shift_r <= shift_r >> DIGIT_W;
          digit_r <= digit_r + DIGIT_CNT_W'(1);
          if (digit_r == DIGIT_CNT_W'(DIGITS - 1)) begin
            if (w_r == last_w_r) begin
              state_r <= S_DONE;
            end else begin
              w_r     <= w_r + WIDX_W'(1);
              state_r <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.dot_value <= DOT_W'(diff);
            out_data_r.out_row   <= row_r;
            out_data_r.out_col   <= col_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/dot_check_pkg.sv
// ----------------------------------------------------------------------------
// dot_check_pkg: dot product tracking for the binary matrix product engine
// Mirrors the two word stores and the vector length, predicts the result of
// every accepted compute item and checks the results that leave the block.
// ----------------------------------------------------------------------------

package dot_check_pkg;

  import bxpm_pkg::*;

  localparam int NUM_WORDS = 1 << WIDX_IN_W;
  localparam int LEN_CAP   = WORD_W * NUM_WORDS;

  class dot_tracker;

    bit [WORD_W-1:0] a_words [IDX_N][NUM_WORDS];
    bit [WORD_W-1:0] b_words [IDX_N][NUM_WORDS];
    int unsigned     vec_len = VECTOR_BITS_RST;
    out_item_t       pending_dots [$];
    int              errors;
    int              dots_checked;

    // Lengths above the store size are clipped, also in the result formula.
    function int unsigned capped_len();
      return (vec_len > LEN_CAP) ? LEN_CAP : vec_len;
    endfunction

    function int span_words();
      return (capped_len() + WORD_W - 1) / WORD_W;
    endfunction

    function out_item_t predict_dot(in_item_t it);
      out_item_t       res;
      int              bits;
      int              nwords;
      int              rem;
      int              count;
      int              dot;
      bit [WORD_W-1:0] x;
      bits   = capped_len();
      nwords = span_words();
      rem    = bits % WORD_W;
      count  = 0;
      for (int w = 0; w < nwords; w++) begin
        x = ~(a_words[it.row_index][w] ^ b_words[it.col_index][w]);
        // The last word keeps only the bits that belong to the vector.
        if (w == nwords - 1 && rem != 0) begin
          x &= {WORD_W{1'b1}} >> (WORD_W - rem);
        end
        count += $countones(x);
      end
      dot = 2 * count - bits;
      res.dot_value = dot[DOT_W-1:0];
      res.out_row   = it.row_index;
      res.out_col   = it.col_index;
      return res;
    endfunction

    function void note_item(in_item_t it);
      case (it.opcode)
        OP_WRITE_A: a_words[it.row_index][it.word_index] = it.data_word;
        OP_WRITE_B: b_words[it.col_index][it.word_index] = it.data_word;
        OP_DOT:     pending_dots.push_back(predict_dot(it));
        default:    ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_dot(out_item_t got);
      out_item_t want;
      if (pending_dots.size() == 0) begin
        report($sformatf("dot result %0d (row %0d col %0d) with no compute item waiting",
                         got.dot_value, got.out_row, got.out_col));
      end else begin
        want = pending_dots.pop_front();
        dots_checked++;
        if (got.dot_value !== want.dot_value) begin
          report($sformatf("dot_value row %0d col %0d: got %0d, expected %0d",
                           want.out_row, want.out_col, got.dot_value, want.dot_value));
        end
        if (got.out_row !== want.out_row) begin
          report($sformatf("out_row: got %0d, expected %0d", got.out_row, want.out_row));
        end
        if (got.out_col !== want.out_col) begin
          report($sformatf("out_col: got %0d, expected %0d", got.out_col, want.out_col));
        end
      end
    endtask

  endclass

endpackage

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the binary XNOR-popcount matrix product engine
// Fills the A and B word stores, issues compute items under many vector
// lengths written over the configuration port, and checks every dot result
// against a tracked copy of the stores, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import bxpm_pkg::*;
  import dot_check_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         ITEM_GOAL  = 1200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  dot_tracker tracker = new();

  bit a_set [IDX_N][NUM_WORDS];
  bit b_set [IDX_N][NUM_WORDS];
  bit quiet;
  int sent_items;
  int lengths_set;

  int unsigned fixed_lens [6]  = '{16384, 32767, 16385, 128, 0, 300};
  int unsigned corner_lens [8] = '{1, 63, 64, 65, 16383, 16384, 16385, 32767};

  binary_xnor_popcount_matmul dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_item(in_data);
      end
      if (out_valid && out_ready) begin
        tracker.check_dot(out_data);
      end
    end
  end

  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Starts after the previous item was accepted; valid only drops when a gap
  // is drawn, so back-to-back items keep it high.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.opcode != OP_UNUSED) begin
      sent_items++;
    end
  endtask

  task automatic put_word(input opcode_t op, input int idx, input int w,
                          input logic [WORD_W-1:0] data);
    in_item_t it;
    it.opcode     = op;
    it.row_index  = (op == OP_WRITE_A) ? IDX_W'(idx) : IDX_W'($urandom);
    it.col_index  = (op == OP_WRITE_B) ? IDX_W'(idx) : IDX_W'($urandom);
    it.word_index = WIDX_IN_W'(w);
    it.data_word  = data;
    send_item(it);
    if (op == OP_WRITE_A) begin
      a_set[idx][w] = 1'b1;
    end else begin
      b_set[idx][w] = 1'b1;
    end
  endtask

  // Every word the compute will read is written first.
  task automatic request_dot(input int r, input int c);
    in_item_t it;
    int       nw;
    nw = tracker.span_words();
    for (int w = 0; w < nw; w++) begin
      if (!a_set[r][w]) begin
        put_word(OP_WRITE_A, r, w, {$urandom, $urandom});
      end
      if (!b_set[c][w]) begin
        put_word(OP_WRITE_B, c, w, {$urandom, $urandom});
      end
    end
    it.opcode     = OP_DOT;
    it.row_index  = IDX_W'(r);
    it.col_index  = IDX_W'(c);
    it.word_index = WIDX_IN_W'($urandom);
    it.data_word  = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it.opcode     = OP_UNUSED;
    it.row_index  = IDX_W'($urandom);
    it.col_index  = IDX_W'($urandom);
    it.word_index = WIDX_IN_W'($urandom);
    it.data_word  = {$urandom, $urandom};
    send_item(it);
  endtask

  // Lets the block run dry: no result owed, and time for a last store write.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_dots.size() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic change_length(input int unsigned vb);
    logic [APB_DW-1:0] wdata;
    logic [APB_DW-1:0] rd;
    settle();
    wdata = $urandom;
    wdata[VB_W-1:0] = vb[VB_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VECTOR_BITS;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.vec_len = wdata[VB_W-1:0];
    lengths_set++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd !== APB_DW'(wdata[VB_W-1:0])) begin
      tracker.report($sformatf("vector_bits read back %0d, expected %0d",
                               rd, wdata[VB_W-1:0]));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (idle_cycles() != 0) begin
        out_ready <= 1'b0;
        // Half the stalls begin only once a result is on the port.
        if ($urandom_range(0, 1) == 1) begin
          @(posedge clk);
          while (!out_valid) @(posedge clk);
          @(negedge clk);
        end
        repeat (idle_cycles()) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned vb;
    int          nw;
    int          pool;
    int          steps;
    int          pick;
    int          w;
    int          phase;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset length of one full word.
    put_word(OP_WRITE_A, 0, 0, '1);
    put_word(OP_WRITE_B, 0, 0, '1);
    request_dot(0, 0);
    put_word(OP_WRITE_B, 0, 0, '0);
    request_dot(0, 0);
    put_word(OP_WRITE_A, IDX_N - 1, 0, {$urandom, $urandom});
    put_word(OP_WRITE_B, IDX_N - 1, 0, {$urandom, $urandom});
    request_dot(IDX_N - 1, IDX_N - 1);
    request_dot(0, IDX_N - 1);
    request_dot(IDX_N - 1, 0);
    send_noise();
    put_word(OP_WRITE_A, IDX_N - 1, NUM_WORDS - 1, '1);
    put_word(OP_WRITE_B, 0, NUM_WORDS - 1, '0);
    // A zero length reads no words, so unwritten rows are fine here.
    change_length(0);
    request_dot(9, 4);
    change_length(1);
    request_dot(0, IDX_N - 1);
    change_length(63);
    request_dot(IDX_N - 1, IDX_N - 1);
    change_length(65);
    request_dot(IDX_N - 1, 0);

    phase = 0;
    while (sent_items < ITEM_GOAL) begin
      if (phase < 6) begin
        vb = fixed_lens[phase];
      end else begin
        case ($urandom_range(0, 9))
          0:                vb = $urandom_range(0, 64);
          1, 2, 3, 4, 5, 6: vb = $urandom_range(1, 512);
          7:                vb = $urandom_range(513, 2048);
          8:                vb = 64 * $urandom_range(1, 8);
          default:          vb = corner_lens[$urandom_range(0, 7)];
        endcase
      end
      change_length(vb);
      quiet = ($urandom_range(0, 3) == 0);
      nw    = tracker.span_words();
      // Long vectors stay on few rows and columns to bound the fill traffic.
      pool  = (nw > 32) ? 1 : (nw > 8) ? 2 : IDX_N;
      steps = (nw > 32) ? 12 : 60;
      repeat (steps) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          request_dot($urandom_range(0, pool - 1), $urandom_range(0, pool - 1));
        end else if (pick < 19) begin
          if (nw != 0 && $urandom_range(0, 3) != 0) begin
            w = $urandom_range(0, nw - 1);
          end else begin
            w = $urandom_range(0, NUM_WORDS - 1);
          end
          put_word(($urandom_range(0, 1) == 1) ? OP_WRITE_A : OP_WRITE_B,
                   $urandom_range(0, pool - 1), w, {$urandom, $urandom});
        end else begin
          send_noise();
        end
      end
      phase++;
    end

    quiet = 1'b0;
    settle();
    repeat (3000) @(posedge clk);
    $display("Sent %0d store and compute items under %0d vector length settings.",
             sent_items, lengths_set);
    $display("Checked %0d dot results, %0d mismatches.", tracker.dots_checked,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(400_000_000);
    $display("Timeout with %0d dot results still owed.", tracker.pending_dots.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
